// ===== rtl/core/pets_pkg.sv =====
// Package with character codes, status codes and the escape lookup for the text escaper.
package pets_pkg;

   // Characters that are rewritten or produced by the escaper.
   localparam logic [7:0] CHR_PERCENT   = 8'h25;
   localparam logic [7:0] CHR_SEMICOLON = 8'h3B;
   localparam logic [7:0] CHR_AMP       = 8'h26;
   localparam logic [7:0] CHR_PIPE      = 8'h7C;
   localparam logic [7:0] CHR_QUOTE     = 8'h27;
   localparam logic [7:0] CHR_SPACE     = 8'h20;
   localparam logic [7:0] CHR_LF        = 8'h0A;
   localparam logic [7:0] CHR_CR        = 8'h0D;
   localparam logic [7:0] CHR_DIG_2     = 8'h32;
   localparam logic [7:0] CHR_DIG_3     = 8'h33;
   localparam logic [7:0] CHR_DIG_5     = 8'h35;
   localparam logic [7:0] CHR_DIG_6     = 8'h36;
   localparam logic [7:0] CHR_DIG_7     = 8'h37;
   localparam logic [7:0] CHR_HEX_B     = 8'h42;
   localparam logic [7:0] CHR_HEX_C     = 8'h43;

   // End status codes.
   localparam logic [1:0] STATUS_CLEAN     = 2'd0;
   localparam logic [1:0] STATUS_ESCAPED   = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   // Capacity after reset and headroom needed for one escape.
   localparam logic [15:0] CAPACITY_RESET = 16'd1024;
   localparam logic [16:0] ESC_LEN        = 17'd3;

   // Maximum number of result bytes that one request can cause.
   localparam int unsigned MAX_RESULTS = 4;

   // Escape lookup result: whether the byte is escaped and its two hex digits.
   typedef struct packed {
      logic       hit;
      logic [7:0] hi;
      logic [7:0] lo;
   } esc_type;

   function automatic esc_type esc_lookup(input logic [7:0] ch);
      esc_type e;
      e = '{hit: 1'b1, hi: CHR_DIG_2, lo: CHR_DIG_5};
      case (ch)
         CHR_PERCENT:   e = '{hit: 1'b1, hi: CHR_DIG_2, lo: CHR_DIG_5};
         CHR_SEMICOLON: e = '{hit: 1'b1, hi: CHR_DIG_3, lo: CHR_HEX_B};
         CHR_AMP:       e = '{hit: 1'b1, hi: CHR_DIG_2, lo: CHR_DIG_6};
         CHR_PIPE:      e = '{hit: 1'b1, hi: CHR_DIG_7, lo: CHR_HEX_C};
         CHR_QUOTE:     e = '{hit: 1'b1, hi: CHR_DIG_2, lo: CHR_DIG_7};
         default:       e = '{hit: 1'b0, hi: 8'h00, lo: 8'h00};
      endcase
      return e;
   endfunction

endpackage

// ===== rtl/core/percent_escape_text_stream_core.sv =====
// Top level of the percent escaper with whitespace collapse for a byte stream.
//
// Usage: string bytes enter on the req_ channel, one request per byte, and a
// request with req_end_of_string set closes the string. Each request causes
// zero to four result bytes on the rsp_ channel: a collapsed space, then the
// byte itself or its three-byte %XX escape. The end request gives one status
// result (has_char low) with end_status clean, escaped or truncated.
// rsp_last_of_run marks the final result of each request.
// The csr_ channel writes the capacity used by the truncation check; write it
// only while the block is idle. csr_ready is always high.
// The first result of a request is shown in the cycle after it is accepted.
// One request per cycle is taken while each request causes at most one result
// and rsp_stall is low; a request with more results holds off the next one
// until its result list, which drains one entry per cycle while rsp_stall is
// low, has drained.
// Reset clears the string state, empties the result list and loads the
// capacity with 1024. While rsp_stall is high the current result holds, and
// req_stall stays high while results are still waiting, unless the last one leaves now.
module percent_escape_text_stream_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_char,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_has_char,
   output logic        rsp_last_of_run,
   output logic [1:0]  rsp_end_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata
);
   import pets_pkg::*;

   // String state.
   logic [15:0] capacity_ff, capacity_in;
   logic        pend_ff, pend_in;
   logic [15:0] count_ff, count_in;
   logic        escd_ff, escd_in;
   logic        trunc_ff, trunc_in;

   // Result list for the request being delivered.
   logic [7:0]  lst_chr_ff [MAX_RESULTS];
   logic [7:0]  lst_chr_in [MAX_RESULTS];
   logic [2:0]  lst_cnt_ff, lst_cnt_in;
   logic [1:0]  lst_idx_ff, lst_idx_in;
   logic        lst_end_ff, lst_end_in;
   logic [1:0]  lst_sts_ff, lst_sts_in;

   logic        req_take;
   logic        rsp_take;
   logic        lst_last;
   logic        is_ws;
   logic        room_ok;
   logic [16:0] need;
   esc_type     esc;
   logic [2:0]  new_cnt;
   logic [7:0]  body [3];
   logic [2:0]  body_len;

   // Output side: the list entry at the read index is the current result.
   assign rsp_valid       = (lst_cnt_ff != 3'd0);
   assign lst_last        = (({1'b0, lst_idx_ff} + 3'd1) == lst_cnt_ff);
   assign rsp_out_char    = lst_end_ff ? 8'h00 : lst_chr_ff[lst_idx_ff];
   assign rsp_has_char    = ~lst_end_ff;
   assign rsp_last_of_run = lst_last;
   assign rsp_end_status  = lst_end_ff ? lst_sts_ff : STATUS_CLEAN;
   assign rsp_take        = rsp_valid & ~rsp_stall;

   // A new request enters when the list is empty or its last entry leaves now.
   assign req_stall = rsp_valid & ~(rsp_take & lst_last);
   assign req_take  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   // Truncation check and byte classification.
   assign need    = {1'b0, count_ff} + {16'd0, pend_ff} + ESC_LEN;
   assign room_ok = ~(need > {1'b0, capacity_ff});
   assign esc     = esc_lookup(req_in_char);
   always_comb begin
      is_ws = req_in_char inside {CHR_SPACE, CHR_LF, CHR_CR};
   end

   // Bytes that stand for the input byte itself, escaped or not.
   always_comb begin
      if (esc.hit) begin
         body[0]  = CHR_PERCENT;
         body[1]  = esc.hi;
         body[2]  = esc.lo;
         body_len = 3'd3;
      end else begin
         body[0]  = req_in_char;
         body[1]  = 8'h00;
         body[2]  = 8'h00;
         body_len = 3'd1;
      end
   end

   // Next string state and new result list for an accepted request.
   always_comb begin
      pend_in  = pend_ff;
      count_in = count_ff;
      escd_in  = escd_ff;
      trunc_in = trunc_ff;
      new_cnt  = 3'd0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         lst_chr_in[i] = lst_chr_ff[i];
      end
      lst_end_in = lst_end_ff;
      lst_sts_in = lst_sts_ff;
      if (req_take) begin
         lst_end_in = 1'b0;
         if (req_end_of_string) begin
            lst_end_in = 1'b1;
            lst_sts_in = trunc_ff ? STATUS_TRUNCATED
                       : (escd_ff ? STATUS_ESCAPED : STATUS_CLEAN);
            new_cnt    = 3'd1;
            pend_in    = 1'b0;
            count_in   = 16'd0;
            escd_in    = 1'b0;
            trunc_in   = 1'b0;
         end else if (trunc_ff) begin
            new_cnt = 3'd0;
         end else if (!room_ok) begin
            // Cut off here; only a waiting space still goes out.
            trunc_in = 1'b1;
            if (pend_ff) begin
               pend_in       = 1'b0;
               lst_chr_in[0] = CHR_SPACE;
               new_cnt       = 3'd1;
               count_in      = count_ff + 16'd1;
            end
         end else if (is_ws) begin
            pend_in = 1'b1;
         end else begin
            // Waiting space first, then the byte or its escape.
            pend_in = 1'b0;
            if (esc.hit) begin
               escd_in = 1'b1;
            end
            if (pend_ff) begin
               lst_chr_in[0] = CHR_SPACE;
               lst_chr_in[1] = body[0];
               lst_chr_in[2] = body[1];
               lst_chr_in[3] = body[2];
               new_cnt       = body_len + 3'd1;
            end else begin
               lst_chr_in[0] = body[0];
               lst_chr_in[1] = body[1];
               lst_chr_in[2] = body[2];
               new_cnt       = body_len;
            end
            count_in = count_ff + {13'd0, new_cnt};
         end
      end
   end

   // List count and read index; the list empties when its last entry leaves.
   always_comb begin
      lst_cnt_in = lst_cnt_ff;
      lst_idx_in = lst_idx_ff;
      if (req_take) begin
         lst_cnt_in = new_cnt;
         lst_idx_in = 2'd0;
      end else if (rsp_take) begin
         if (lst_last) begin
            lst_cnt_in = 3'd0;
            lst_idx_in = 2'd0;
         end else begin
            lst_idx_in = lst_idx_ff + 2'd1;
         end
      end
   end

   // Capacity register.
   always_comb begin
      capacity_in = capacity_ff;
      if (csr_valid && csr_ready) begin
         capacity_in = csr_wdata;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         pend_ff     <= 1'b0;
         count_ff    <= 16'd0;
         escd_ff     <= 1'b0;
         trunc_ff    <= 1'b0;
         lst_cnt_ff  <= 3'd0;
         lst_idx_ff  <= 2'd0;
      end else begin
         capacity_ff <= capacity_in;
         pend_ff     <= pend_in;
         count_ff    <= count_in;
         escd_ff     <= escd_in;
         trunc_ff    <= trunc_in;
         lst_cnt_ff  <= lst_cnt_in;
         lst_idx_ff  <= lst_idx_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         lst_chr_ff[i] <= lst_chr_in[i];
      end
      lst_end_ff <= lst_end_in;
      lst_sts_ff <= lst_sts_in;
   end

`ifndef ASSERT_OFF
   // A request only enters when the previous list is finished.
   a_take_when_drained: assert property (@(posedge clock) disable iff (reset)
      (req_take && rsp_valid) |-> (rsp_take && lst_last))
      else $error("request accepted while results were still waiting");

   // After truncation, data bytes give no result.
   a_trunc_silent: assert property (@(posedge clock) disable iff (reset)
      (req_take && !req_end_of_string && trunc_ff) |=> !rsp_valid)
      else $error("byte after truncation produced a result");

   // The end request gives a single status result.
   a_end_status: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_end_of_string) |=>
         (rsp_valid && !rsp_has_char && rsp_last_of_run && count_ff == 16'd0))
      else $error("end request did not give one status result");

   // The read index stays inside the list.
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, lst_idx_ff} < lst_cnt_ff))
      else $error("result index beyond list length");
`endif

endmodule
